// ----- rtl/agc_pkg.sv -----
package agc_pkg;

    // Block configuration
    localparam int CORDIC_STAGES = 16;  // 8 .. 32
    localparam int FRACTION_BITS = 16;  // 8 .. 24
    localparam int SQRT_STEPS    = 32;  // one root bit per cell, 64-bit radicand

    // Fixed field widths
    localparam int POS_W      = 32;
    localparam int CENTER_W   = 23;
    localparam int REPEAT_W   = 24;
    localparam int ANGLE_W    = 17;
    localparam int DIST_W     = 32;
    localparam int U_W        = 16;
    localparam int D_W        = 34;     // doubled offset, signed
    localparam int CW         = 62;     // CORDIC vector width, signed
    localparam int PW         = 34;     // CORDIC phase width, signed, 2^-32 turn units
    localparam int PRESCALE_SH = 24;
    localparam int STEP_W     = 5;
    localparam int SQ_W       = 64;
    localparam int A_W        = FRACTION_BITS + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [PW-1:0] HALF_TURN = 34'sh080000000;
    localparam logic signed [PW-1:0] FULL_TURN = 34'sh100000000;

    // Pipeline stage positions
    localparam int ST_IN    = 0;
    localparam int ST_PRE   = 1;
    localparam int ST_COR   = 2;                      // first CORDIC cell
    localparam int ST_ANG   = ST_COR + CORDIC_STAGES;
    localparam int ST_U     = ST_ANG + 1;
    localparam int PAD_LEN  = SQRT_STEPS - CORDIC_STAGES;
    localparam int ST_SQ    = 2;
    localparam int ST_SUM   = 3;
    localparam int ST_ROOT  = 4;                      // first square-root cell
    localparam int ST_OUT   = ST_ROOT + SQRT_STEPS;
    localparam int DEPTH    = ST_OUT + 1;

    // atan(2^-i) in 2^-32 turn units
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_REPEAT,
        CFG_MIRROR
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
    } t_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_coord;
        logic [DIST_W-1:0]  distance_coord;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [PW-1:0] phase;
        logic                 zero;
    } t_cordic;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
        logic            sat;
    } t_sqrt;

endpackage

// ----- rtl/agc_cordic_cell.sv -----
module agc_cordic_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [agc_pkg::STEP_W-1:0]  i_shift,
    input  logic [31:0]                 i_atan,
    input  agc_pkg::t_cordic            i_d,
    output agc_pkg::t_cordic            o_q
);
    import agc_pkg::*;

    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [PW-1:0] w_atan;
    t_cordic              n_q;
    t_cordic              r_q;

    always_comb begin
        w_xs   = i_d.x >>> i_shift;
        w_ys   = i_d.y >>> i_shift;
        w_atan = $signed({{(PW-32){1'b0}}, i_atan});
        n_q    = i_d;
        // rotate toward the x axis, both updates from the incoming vector
        if (!i_d.y[CW-1]) begin
            n_q.x     = i_d.x + w_ys;
            n_q.y     = i_d.y - w_xs;
            n_q.phase = i_d.phase + w_atan;
        end else begin
            n_q.x     = i_d.x - w_ys;
            n_q.y     = i_d.y + w_xs;
            n_q.phase = i_d.phase - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/agc_sqrt_cell.sv -----
module agc_sqrt_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [agc_pkg::STEP_W-1:0]  i_step,
    input  agc_pkg::t_sqrt              i_d,
    output agc_pkg::t_sqrt              o_q
);
    import agc_pkg::*;

    logic [5:0]      w_pos;
    logic [SQ_W-1:0] w_bit;
    logic [SQ_W-1:0] w_trial;
    t_sqrt           n_q;
    t_sqrt           r_q;

    always_comb begin
        // trial bit weight 4^(31 - step)
        w_pos   = 6'd62 - {i_step, 1'b0};
        w_bit   = {{(SQ_W-1){1'b0}}, 1'b1} << w_pos;
        w_trial = i_d.root + w_bit;
        n_q     = i_d;
        if (i_d.rem >= w_trial) begin
            n_q.rem  = i_d.rem - w_trial;
            n_q.root = (i_d.root >> 1) + w_bit;
        end else begin
            n_q.root = i_d.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/agc_pipe_ctrl.sv -----
module agc_pipe_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [agc_pkg::DEPTH-1:0]  o_en
);
    import agc_pkg::*;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic [DEPTH-1:0] w_ready;
    logic [DEPTH-1:0] w_prev;

    // a stage can load when it or some stage after it is empty, or the output drains
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            w_ready[k] = !i_stall || ((r_vld >> k) != ({DEPTH{1'b1}} >> k));
        end
        w_prev = {r_vld[DEPTH-2:0], i_valid};
        n_vld  = (w_ready & w_prev) | (~w_ready & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_en    = w_ready;
    assign o_stall = !w_ready[0];
    assign o_valid = r_vld[DEPTH-1];

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while a pipeline slot is free");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction not held in first stage");

    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");
`endif

endmodule

// ----- rtl/angular_gradient_coordinate_unit.sv -----
// Throughput: one transaction per cycle while the output is not stalled; the 32-cell
// square-root chain sets the depth, and the CORDIC result is delayed in a short shift
// line to meet it. Stalls back up through per-stage valid bits, so bubbles are squeezed out.
// Reset (synchronous, active low) empties the pipeline and restores the
// register defaults: centre 0.5, 0.5, repeat 1.0, mirror off.
module angular_gradient_coordinate_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  agc_pkg::t_in                    i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output agc_pkg::t_out                   o_data,
    input  logic                            i_cfg_we,
    input  logic [agc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [agc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import agc_pkg::*;

    logic [DEPTH-1:0] w_en;

    // configuration
    logic signed [CENTER_W-1:0] r_center_x;
    logic signed [CENTER_W-1:0] r_center_y;
    logic [REPEAT_W-1:0]        r_repeat;
    logic                       r_mirror;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= 23'sd32768;
            r_center_y <= 23'sd32768;
            r_repeat   <= 24'd65536;
            r_mirror   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X: r_center_x <= $signed(i_cfg_data[CENTER_W-1:0]);
                CFG_CENTER_Y: r_center_y <= $signed(i_cfg_data[CENTER_W-1:0]);
                CFG_REPEAT:   r_repeat   <= i_cfg_data[REPEAT_W-1:0];
                CFG_MIRROR:   r_mirror   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    agc_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_en    (w_en)
    );

    // stage 0: doubled offsets
    logic signed [D_W-1:0] w_diff_x;
    logic signed [D_W-1:0] w_diff_y;
    logic signed [D_W-1:0] r_dx;
    logic signed [D_W-1:0] r_dy;

    assign w_diff_x = {{(D_W-POS_W){i_data.x_pos[POS_W-1]}}, i_data.x_pos}
                    - {{(D_W-CENTER_W){r_center_x[CENTER_W-1]}}, r_center_x};
    assign w_diff_y = {{(D_W-POS_W){i_data.y_pos[POS_W-1]}}, i_data.y_pos}
                    - {{(D_W-CENTER_W){r_center_y[CENTER_W-1]}}, r_center_y};

    always_ff @(posedge i_clk) begin
        if (w_en[ST_IN]) begin
            r_dx <= {w_diff_x[D_W-2:0], 1'b0};
            r_dy <= {w_diff_y[D_W-2:0], 1'b0};
        end
    end

    // stage 1: CORDIC pre-rotation into the right half plane, magnitudes
    logic signed [CW-1:0] w_x0;
    logic signed [CW-1:0] w_y0;
    logic [D_W-1:0]       w_abs_x;
    logic [D_W-1:0]       w_abs_y;
    t_cordic              n_cor0;
    t_cordic              r_cor0;
    logic [DIST_W-1:0]    r_abs_a;
    logic [DIST_W-1:0]    r_abs_b;
    logic                 r_sat1;

    always_comb begin
        w_x0 = {{(CW-D_W){r_dy[D_W-1]}}, r_dy} <<< PRESCALE_SH;
        w_y0 = {{(CW-D_W){r_dx[D_W-1]}}, r_dx} <<< PRESCALE_SH;
        n_cor0.zero = (r_dx == '0) && (r_dy == '0);
        if (w_x0[CW-1]) begin
            n_cor0.x     = -w_x0;
            n_cor0.y     = -w_y0;
            n_cor0.phase = w_y0[CW-1] ? -HALF_TURN : HALF_TURN;
        end else begin
            n_cor0.x     = w_x0;
            n_cor0.y     = w_y0;
            n_cor0.phase = '0;
        end
        w_abs_x = r_dx[D_W-1] ? D_W'(-r_dx) : D_W'(r_dx);
        w_abs_y = r_dy[D_W-1] ? D_W'(-r_dy) : D_W'(r_dy);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PRE]) begin
            r_cor0  <= n_cor0;
            r_abs_a <= w_abs_x[DIST_W-1:0];
            r_abs_b <= w_abs_y[DIST_W-1:0];
            r_sat1  <= (|w_abs_x[D_W-1:DIST_W]) || (|w_abs_y[D_W-1:DIST_W]);
        end
    end

    // CORDIC chain
    t_cordic w_cor [CORDIC_STAGES+1];
    assign w_cor[0] = r_cor0;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        agc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en[ST_COR+i]),
            .i_shift (STEP_W'(i)),
            .i_atan  (ATAN_TURNS[i]),
            .i_d     (w_cor[i]),
            .o_q     (w_cor[i+1])
        );
    end

    // angle: recentre, clamp at the seam, truncate to turns
    logic signed [PW-1:0] w_ang;
    logic signed [PW-1:0] w_ang_c;
    logic [A_W-1:0]       r_ang_a;

    always_comb begin
        w_ang = w_cor[CORDIC_STAGES].phase + HALF_TURN;
        if (w_cor[CORDIC_STAGES].zero) begin
            w_ang_c = HALF_TURN;
        end else if (w_ang < 0) begin
            w_ang_c = '0;
        end else if (w_ang > FULL_TURN) begin
            w_ang_c = FULL_TURN;
        end else begin
            w_ang_c = w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_ANG]) begin
            r_ang_a <= w_ang_c[32:32-FRACTION_BITS];
        end
    end

    // repeat: keep the fractional turns of angle * repeat
    logic [A_W+REPEAT_W-1:0] w_prod;
    logic [U_W-1:0]          r_u;
    logic [U_W-1:0]          w_u_last;

    assign w_prod = {{REPEAT_W{1'b0}}, r_ang_a} * {{A_W{1'b0}}, r_repeat};

    always_ff @(posedge i_clk) begin
        if (w_en[ST_U]) begin
            r_u <= w_prod[FRACTION_BITS+U_W-1:FRACTION_BITS];
        end
    end

    if (PAD_LEN > 0) begin : g_pad
        logic [U_W-1:0] r_pad    [PAD_LEN];
        logic [U_W-1:0] w_pad_in [PAD_LEN];

        assign w_pad_in[0] = r_u;
        for (genvar k = 1; k < PAD_LEN; k++) begin : g_link
            assign w_pad_in[k] = r_pad[k-1];
        end

        always_ff @(posedge i_clk) begin
            for (int k = 0; k < PAD_LEN; k++) begin
                if (w_en[ST_U+1+k]) begin
                    r_pad[k] <= w_pad_in[k];
                end
            end
        end

        assign w_u_last = r_pad[PAD_LEN-1];
    end else begin : g_nopad
        assign w_u_last = r_u;
    end

    // distance: squares, sum with overflow, then the root chain
    logic [SQ_W-1:0] r_sq_a;
    logic [SQ_W-1:0] r_sq_b;
    logic            r_sat2;
    logic [SQ_W:0]   w_sum;
    t_sqrt           r_sq0;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SQ]) begin
            r_sq_a <= {{(SQ_W-DIST_W){1'b0}}, r_abs_a} * {{(SQ_W-DIST_W){1'b0}}, r_abs_a};
            r_sq_b <= {{(SQ_W-DIST_W){1'b0}}, r_abs_b} * {{(SQ_W-DIST_W){1'b0}}, r_abs_b};
            r_sat2 <= r_sat1;
        end
    end

    assign w_sum = {1'b0, r_sq_a} + {1'b0, r_sq_b};

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_sq0.rem  <= w_sum[SQ_W-1:0];
            r_sq0.root <= '0;
            r_sq0.sat  <= r_sat2 || w_sum[SQ_W];
        end
    end

    t_sqrt w_sq [SQRT_STEPS+1];
    assign w_sq[0] = r_sq0;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        agc_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en[ST_ROOT+j]),
            .i_step (STEP_W'(j)),
            .i_d    (w_sq[j]),
            .o_q    (w_sq[j+1])
        );
    end

    // output: mirror fold, distance saturation
    logic [ANGLE_W-1:0] w_u2;
    logic [ANGLE_W-1:0] w_angle;
    t_out               r_out;

    always_comb begin
        w_u2 = {w_u_last, 1'b0};
        if (r_mirror && w_u2[ANGLE_W-1]) begin
            w_angle = ANGLE_W'(18'h20000 - {1'b0, w_u2});
        end else if (r_mirror) begin
            w_angle = w_u2;
        end else begin
            w_angle = {1'b0, w_u_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_out.angle_coord    <= w_angle;
            r_out.distance_coord <= w_sq[SQRT_STEPS].sat ? '1
                                  : w_sq[SQRT_STEPS].root[DIST_W-1:0];
        end
    end

    assign o_data = r_out;

`ifndef SYNTHESIS
    a_angle_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.angle_coord <= 17'd65536))
        else $error("angle coordinate above one turn");

    a_empty_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output stage");

    a_output_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled output transaction changed");
`endif

endmodule

// ----- test/angular_gradient_coordinate_unit_tb.sv -----
`timescale 1ns / 1ps

module angular_gradient_coordinate_unit_tb;
    import agc_pkg::*;

    localparam int  CYCLE_LIMIT = 300000;
    localparam longint HALF_T   = 64'sh80000000;
    localparam longint FULL_T   = 64'sh100000000;
    localparam longint PRE_MUL  = 64'sd16777216;

    // atan(2^-i) in 2^-32 turn units
    localparam longint ATAN_TAB [32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
        64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
        64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in                   i_data;
    logic                  o_valid;
    logic                  i_stall;
    t_out                  o_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // shadow copy of the block's registers
    logic signed [CENTER_W-1:0] m_cx;
    logic signed [CENTER_W-1:0] m_cy;
    logic [REPEAT_W-1:0]        m_repeat;
    logic                       m_mirror;

    t_out polar_q [$];
    int   err_count;
    bit   src_idle_en;
    bit   sink_idle_en;

    angular_gradient_coordinate_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'h1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [DIST_W-1:0] radius_of(longint dx, longint dy);
        logic [63:0] a, b, s, t, sum, r;
        a = (dx < 0) ? -dx : dx;
        b = (dy < 0) ? -dy : dy;
        if (a > 64'hFFFF_FFFF || b > 64'hFFFF_FFFF) return '1;
        s   = a * a;
        t   = b * b;
        sum = s + t;
        if (sum < s) return '1;
        r = int_sqrt(sum);
        return (r > 64'hFFFF_FFFF) ? '1 : r[DIST_W-1:0];
    endfunction

    // vectoring CORDIC, result in 2^-32 turn units, clamped to 0 .. 1 turn
    function automatic longint turns_of(longint dx, longint dy);
        longint vx, vy, ph, xs, ys, ang;
        if (dx == 0 && dy == 0) return HALF_T;
        vx = dy * PRE_MUL;
        vy = dx * PRE_MUL;
        ph = 0;
        if (vx < 0) begin
            ph = (vy >= 0) ? HALF_T : -HALF_T;
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx = vx + ys;
                vy = vy - xs;
                ph = ph + ATAN_TAB[i];
            end else begin
                vx = vx - ys;
                vy = vy + xs;
                ph = ph - ATAN_TAB[i];
            end
        end
        ang = ph + HALF_T;
        if (ang < 0) ang = 0;
        if (ang > FULL_T) ang = FULL_T;
        return ang;
    endfunction

    function automatic t_out predict_polar(t_in d);
        longint      x, y, dx, dy;
        logic [63:0] ang, a, prod, frac, u;
        t_out        r;
        x    = longint'(signed'(d.x_pos));
        y    = longint'(signed'(d.y_pos));
        dx   = 2 * (x - longint'(m_cx));
        dy   = 2 * (y - longint'(m_cy));
        ang  = turns_of(dx, dy);
        a    = ang >> (32 - FRACTION_BITS);
        prod = a * {40'd0, m_repeat};
        frac = prod & ((64'h1 << (FRACTION_BITS + 16)) - 1);
        u    = frac >> FRACTION_BITS;
        if (m_mirror) begin
            u = u * 2;
            if (u >= 64'd65536) u = 64'd131072 - u;
        end
        r.angle_coord    = u[ANGLE_W-1:0];
        r.distance_coord = radius_of(dx, dy);
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_CENTER_X: m_cx     = data[CENTER_W-1:0];
            CFG_CENTER_Y: m_cy     = data[CENTER_W-1:0];
            CFG_REPEAT:   m_repeat = data[REPEAT_W-1:0];
            CFG_MIRROR:   m_mirror = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for the pipeline to empty before touching registers
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (polar_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(int cx, int cy, logic [23:0] rep, logic [23:0] mir);
        drain_pipeline();
        write_reg(CFG_CENTER_X, 24'(cx));
        write_reg(CFG_CENTER_Y, 24'(cy));
        write_reg(CFG_REPEAT, rep);
        write_reg(CFG_MIRROR, mir);
    endtask

    task automatic send_coord(logic [31:0] x, logic [31:0] y);
        t_in d;
        d.x_pos = x;
        d.y_pos = y;
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        polar_q.push_back(predict_polar(d));
    endtask

    task automatic send_random_coord();
        longint ox, oy;
        int     mode;
        mode = $urandom_range(0, 9);
        if (mode < 3) begin
            send_coord($urandom, $urandom);
        end else begin
            if (mode < 5) begin
                ox = longint'($urandom_range(0, 8192)) - 4096;
                oy = longint'($urandom_range(0, 8192)) - 4096;
            end else begin
                ox = longint'($urandom_range(0, 13107200)) - 6553600;
                oy = longint'($urandom_range(0, 13107200)) - 6553600;
            end
            // points on the axes through the centre, the seam among them
            if (mode == 8) ox = 0;
            if (mode == 9) oy = 0;
            send_coord(32'(longint'(m_cx) + ox), 32'(longint'(m_cy) + oy));
        end
    endtask

    task automatic test_default_geometry();
        send_coord(32'd32768, 32'd32768);            // zero offset
        send_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_coord(32'h8000_0000, 32'h8000_0000);
        send_coord(32'h8000_0000, 32'h7FFF_FFFF);
        send_coord(32'h7FFF_FFFF, 32'h8000_0000);
        send_coord(32'd32768, 32'd0);                // on the seam
        send_coord(32'd32767, 32'd0);
        send_coord(32'd32769, 32'd0);
        send_coord(32'd65536, 32'd32768);
        send_coord(32'd0, 32'd32768);
        send_coord(32'd32768, 32'd65536);
        send_coord(32'd0, 32'd0);
        send_coord(32'd1, 32'd1);
        send_coord(32'hFFFF_FFFF, 32'h5555_5555);
    endtask

    task automatic test_config_extremes();
        load_settings(3276800, -3276800, 24'hFF_FFFF, 24'd1);
        send_coord(32'd0, 32'd0);
        send_coord(32'h7FFF_FFFF, 32'h8000_0000);
        send_coord(32'd3276800, 32'd3276800);
        load_settings(-3276800, 3276800, 24'd0, 24'd0);
        send_coord(32'hAAAA_AAAA, 32'h1234_5678);
        send_coord(32'd0, 32'd3276800);
        // centre patterns outside the nominal range, one with bit 23 of the data set
        load_settings(32'h00C0_0000, 32'h003F_FFFF, 24'd196608, 24'hFF_FFFF);
        send_coord(32'd0, 32'd0);
        send_coord(32'h0040_0000, 32'h8000_0000);
        load_settings(32'h007F_FFFF, 0, 24'd65536, 24'd1);
        send_coord(32'hFFFF_FFFF, 32'd5);
        send_coord(32'h0000_1000, 32'hFFFF_0000);
    endtask

    task automatic load_random_settings();
        int          cx, cy;
        logic [23:0] rep;
        case ($urandom_range(0, 3))
            0: begin cx = 3276800;  cy = -3276800; end
            1: begin cx = $urandom; cy = $urandom; end
            default: begin
                cx = int'($urandom_range(0, 6553600)) - 3276800;
                cy = int'($urandom_range(0, 6553600)) - 3276800;
            end
        endcase
        case ($urandom_range(0, 5))
            0: rep = 24'($urandom_range(0, 65535));
            1: rep = 24'hFF_FFFF;
            2: rep = 24'd65536;
            default: rep = 24'($urandom_range(65536, 16777215));
        endcase
        load_settings(cx, cy, rep, 24'($urandom));
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 8; p++) begin
            load_random_settings();
            for (int n = 0; n < 60; n++) send_random_coord();
        end
    endtask

    task automatic test_full_rate();
        load_random_settings();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        for (int n = 0; n < 60; n++) send_random_coord();
    endtask

    // downstream stall bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (sink_idle_en && $urandom_range(0, 6) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (polar_q.size() == 0) begin
                $display("%0t: result with nothing pending: angle %0d distance %0d",
                         $time, o_data.angle_coord, o_data.distance_coord);
                err_count++;
            end else begin
                want = polar_q.pop_front();
                if (o_data.angle_coord !== want.angle_coord) begin
                    $display("%0t: angle_coord expected %0d actual %0d",
                             $time, want.angle_coord, o_data.angle_coord);
                    err_count++;
                end
                if (o_data.distance_coord !== want.distance_coord) begin
                    $display("%0t: distance_coord expected %0d actual %0d",
                             $time, want.distance_coord, o_data.distance_coord);
                    err_count++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        i_stall      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        err_count    = 0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        m_cx         = 23'sd32768;
        m_cy         = 23'sd32768;
        m_repeat     = 24'd65536;
        m_mirror     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_geometry();
        test_config_extremes();
        test_random_settings();
        test_full_rate();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (polar_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/agc_pkg.sv
rtl/agc_cordic_cell.sv
rtl/agc_sqrt_cell.sv
rtl/agc_pipe_ctrl.sv
rtl/angular_gradient_coordinate_unit.sv
test/angular_gradient_coordinate_unit_tb.sv
